FILE: design/rhcc_pkg.sv
// ----------------------------------------------------------------------------
// rhcc_pkg: shared definitions of the colour converter
// Operation codes and fixed port widths.
// ----------------------------------------------------------------------------
package rhcc_pkg;

  localparam int IN_W  = 16;
  localparam int OUT_W = 13;

  localparam logic [1:0] FUNC_RGB2HSB = 2'd0;
  localparam logic [1:0] FUNC_HSB2RGB = 2'd1;
  localparam logic [1:0] FUNC_SCALE   = 2'd2;

endpackage

FILE: design/rgb_hsb_color_converter_unit.sv
// ----------------------------------------------------------------------------
// rgb_hsb_color_converter_unit: pipelined RGB / HSB pixel converter
// Throughput is one beat per cycle when not stalled; the FRAC_BITS + 1
// radix-2 divider stages and the two multiplier stages are fully pipelined.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Reset (rst_ni low) empties every stage; payload registers are not reset.
// ----------------------------------------------------------------------------
module rgb_hsb_color_converter_unit #(
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  func_i,
  input  logic signed [rhcc_pkg::IN_W-1:0] in_a_i,
  input  logic signed [rhcc_pkg::IN_W-1:0] in_b_i,
  input  logic signed [rhcc_pkg::IN_W-1:0] in_c_i,
  input  logic [rhcc_pkg::IN_W-1:0]   gain_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rhcc_pkg::OUT_W-1:0]  out_a_o,
  output logic [rhcc_pkg::OUT_W-1:0]  out_b_o,
  output logic [rhcc_pkg::OUT_W-1:0]  out_c_o
);

  localparam int F   = FRAC_BITS;
  localparam int W   = F + 1;      // 0..ONE
  localparam int DW  = F + 3;      // 6 * delta, hue numerator
  localparam int HRW = F + 4;      // hue divider remainder
  localparam int SRW = F + 2;      // saturation divider remainder
  localparam int PW  = W + rhcc_pkg::IN_W;
  localparam int ONE_I = 1 << F;
  localparam logic [W-1:0] ONE_V = W'(ONE_I);

  // Every stage advances when the output register is free or being emptied.
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  function automatic logic [W-1:0] clamp_unit(input logic signed [rhcc_pkg::IN_W-1:0] x);
    int xi;
    xi = int'(x);
    if (xi < 0) begin
      return '0;
    end else if (xi > ONE_I) begin
      return ONE_V;
    end
    return W'(xi);
  endfunction

  // --------------------------------------------------------------------------
  // Stage 1: clamp the channels, take the hue modulo one turn.
  // --------------------------------------------------------------------------
  logic                    c_vld_q;
  logic [1:0]              c_func_q;
  logic [W-1:0]            c_r_q, c_g_q, c_b_q;
  logic [F-1:0]            c_hue_q;
  logic [rhcc_pkg::IN_W-1:0] c_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (adv) begin
      c_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_func_q <= func_i;
      c_r_q    <= clamp_unit(in_a_i);
      c_g_q    <= clamp_unit(in_b_i);
      c_b_q    <= clamp_unit(in_c_i);
      c_hue_q  <= F'(in_a_i);
      c_gain_q <= gain_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: max, min, delta and the hue numerator in the red, green, blue
  // tie order. For hsb to rgb the clamped brightness rides in the max slot.
  // --------------------------------------------------------------------------
  logic          m_vld_q;
  logic [1:0]    m_func_q;
  logic [W-1:0]  m_mx_q, m_d_q, m_ps_q;
  logic [F-1:0]  m_ph_q;
  logic [DW-1:0] m_num_q, m_d6_q;
  logic [rhcc_pkg::IN_W-1:0] m_gain_q;

  logic [W-1:0]  mx_c, mn_c, d_c;
  logic [DW-1:0] num_c, d6_c;

  always_comb begin
    int ni;
    int di;
    mx_c = c_r_q;
    mn_c = c_r_q;
    if (c_g_q > mx_c) mx_c = c_g_q;
    if (c_b_q > mx_c) mx_c = c_b_q;
    if (c_g_q < mn_c) mn_c = c_g_q;
    if (c_b_q < mn_c) mn_c = c_b_q;
    d_c = mx_c - mn_c;
    di  = int'(d_c);
    if (c_r_q == mx_c) begin
      ni = int'(c_g_q) - int'(c_b_q);
    end else if (c_g_q == mx_c) begin
      ni = 2 * di + int'(c_b_q) - int'(c_r_q);
    end else begin
      ni = 4 * di + int'(c_r_q) - int'(c_g_q);
    end
    if (ni < 0) begin
      ni = ni + 6 * di;
    end
    num_c = DW'(ni);
    d6_c  = DW'(6 * di);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_func_q <= c_func_q;
      m_mx_q   <= (c_func_q == rhcc_pkg::FUNC_HSB2RGB) ? c_b_q : mx_c;
      m_d_q    <= d_c;
      m_ps_q   <= c_g_q;
      m_ph_q   <= c_hue_q;
      m_num_q  <= num_c;
      m_d6_q   <= d6_c;
      m_gain_q <= c_gain_q;
    end
  end

  // --------------------------------------------------------------------------
  // Divider stages 0..F: one saturation quotient bit per stage, one hue bit per stage from stage 1.
  // Stage 0 also forms the brightness gain product.
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [1:0]     func;
    logic           grey;
    logic [W-1:0]   mx;
    logic [W-1:0]   sq;
    logic [SRW-1:0] srem;
    logic [F-1:0]   hq;
    logic [HRW-1:0] hrem;
    logic [DW-1:0]  dsor;
    logic [F-1:0]   ph;
    logic [W-1:0]   ps;
    logic [PW-1:0]  prod;
  } div_t;

  logic [F:0] dv_vld_q;
  div_t       dv_q [0:F];
  div_t       dv_d [0:F];

  always_comb begin
    logic [SRW-1:0] sr;
    sr             = SRW'(m_d_q);
    dv_d[0].func   = m_func_q;
    dv_d[0].grey   = (m_d_q == '0);
    dv_d[0].mx     = m_mx_q;
    dv_d[0].ph     = m_ph_q;
    dv_d[0].ps     = m_ps_q;
    dv_d[0].dsor   = m_d6_q;
    dv_d[0].hrem   = HRW'(m_num_q);
    dv_d[0].hq     = '0;
    dv_d[0].prod   = PW'(m_mx_q) * PW'(m_gain_q);
    if (sr >= SRW'(m_mx_q)) begin
      dv_d[0].sq   = W'(1);
      dv_d[0].srem = sr - SRW'(m_mx_q);
    end else begin
      dv_d[0].sq   = '0;
      dv_d[0].srem = sr;
    end
  end

  for (genvar k = 1; k <= F; k++) begin : g_div
    always_comb begin
      logic [SRW-1:0] sr;
      logic [HRW-1:0] hr;
      dv_d[k] = dv_q[k-1];
      sr = {dv_q[k-1].srem[SRW-2:0], 1'b0};
      hr = {dv_q[k-1].hrem[HRW-2:0], 1'b0};
      if (sr >= SRW'(dv_q[k-1].mx)) begin
        dv_d[k].srem = sr - SRW'(dv_q[k-1].mx);
        dv_d[k].sq   = {dv_q[k-1].sq[W-2:0], 1'b1};
      end else begin
        dv_d[k].srem = sr;
        dv_d[k].sq   = {dv_q[k-1].sq[W-2:0], 1'b0};
      end
      if (hr >= HRW'(dv_q[k-1].dsor)) begin
        dv_d[k].hrem = hr - HRW'(dv_q[k-1].dsor);
        dv_d[k].hq   = {dv_q[k-1].hq[F-2:0], 1'b1};
      end else begin
        dv_d[k].hrem = hr;
        dv_d[k].hq   = {dv_q[k-1].hq[F-2:0], 1'b0};
      end
    end
  end

  for (genvar k = 0; k <= F; k++) begin : g_div_q
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[k] <= (k == 0) ? m_vld_q : dv_vld_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Merge stage: pick hue, saturation, brightness per operation; saturate
  // the scaled brightness.
  // --------------------------------------------------------------------------
  logic         h_vld_q;
  logic [1:0]   h_func_q;
  logic [F-1:0] h_h_q;
  logic [W-1:0] h_s_q, h_v_q;

  logic [PW-F-1:0] vp_c;
  logic [F-1:0]    hh_c;
  logic [W-1:0]    hs_c, hv_c;

  always_comb begin
    vp_c = (PW-F)'(dv_q[F].prod >> F);
    hh_c = dv_q[F].grey ? '0 : dv_q[F].hq;
    hs_c = dv_q[F].grey ? '0 : dv_q[F].sq;
    hv_c = dv_q[F].mx;
    if (dv_q[F].func == rhcc_pkg::FUNC_HSB2RGB) begin
      hh_c = dv_q[F].ph;
      hs_c = dv_q[F].ps;
    end else if (dv_q[F].func == rhcc_pkg::FUNC_SCALE) begin
      hv_c = (vp_c > (PW-F)'(ONE_I)) ? ONE_V : W'(vp_c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else if (adv) begin
      h_vld_q <= dv_vld_q[F];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_func_q <= dv_q[F].func;
      h_h_q    <= hh_c;
      h_s_q    <= hs_c;
      h_v_q    <= hv_c;
    end
  end

  // --------------------------------------------------------------------------
  // RGB stage 1: sector, fraction and the saturation products.
  // --------------------------------------------------------------------------
  logic         r1_vld_q;
  logic [1:0]   r1_func_q;
  logic [F-1:0] r1_h_q;
  logic [W-1:0] r1_s_q, r1_v_q, r1_t2_q, r1_t3_q, r1_f1_q;
  logic [2:0]   r1_sec_q;

  logic [DW-1:0]  hd_c;
  logic [F-1:0]   fr_c;
  logic [W+F-1:0] ps1_c;
  logic [2*W-1:0] ps2_c, pv1_c;

  assign hd_c  = DW'(h_h_q) * DW'(6);
  assign fr_c  = hd_c[F-1:0];
  assign ps1_c = (W+F)'(h_s_q) * (W+F)'(fr_c);
  assign ps2_c = (2*W)'(h_s_q) * (2*W)'(ONE_V - W'(fr_c));
  assign pv1_c = (2*W)'(h_v_q) * (2*W)'(ONE_V - h_s_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_vld_q <= 1'b0;
    end else if (adv) begin
      r1_vld_q <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1_func_q <= h_func_q;
      r1_h_q    <= h_h_q;
      r1_s_q    <= h_s_q;
      r1_v_q    <= h_v_q;
      r1_sec_q  <= hd_c[DW-1:F];
      r1_t2_q   <= ONE_V - W'(ps1_c >> F);
      r1_t3_q   <= ONE_V - W'(ps2_c >> F);
      r1_f1_q   <= W'(pv1_c >> F);
    end
  end

  // --------------------------------------------------------------------------
  // RGB stage 2: brightness products.
  // --------------------------------------------------------------------------
  logic         r2_vld_q;
  logic [1:0]   r2_func_q;
  logic [F-1:0] r2_h_q;
  logic [W-1:0] r2_s_q, r2_v_q, r2_f1_q, r2_f2_q, r2_f3_q;
  logic [2:0]   r2_sec_q;

  logic [2*W-1:0] pf2_c, pf3_c;
  assign pf2_c = (2*W)'(r1_v_q) * (2*W)'(r1_t2_q);
  assign pf3_c = (2*W)'(r1_v_q) * (2*W)'(r1_t3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_vld_q <= 1'b0;
    end else if (adv) begin
      r2_vld_q <= r1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r2_func_q <= r1_func_q;
      r2_h_q    <= r1_h_q;
      r2_s_q    <= r1_s_q;
      r2_v_q    <= r1_v_q;
      r2_sec_q  <= r1_sec_q;
      r2_f1_q   <= r1_f1_q;
      r2_f2_q   <= W'(pf2_c >> F);
      r2_f3_q   <= W'(pf3_c >> F);
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: six-sector placement, then mask to the port width.
  // --------------------------------------------------------------------------
  logic [W-1:0] oa_c, ob_c, oc_c;

  always_comb begin
    case (r2_sec_q)
      3'd0: begin oa_c = r2_v_q;  ob_c = r2_f3_q; oc_c = r2_f1_q; end
      3'd1: begin oa_c = r2_f2_q; ob_c = r2_v_q;  oc_c = r2_f1_q; end
      3'd2: begin oa_c = r2_f1_q; ob_c = r2_v_q;  oc_c = r2_f3_q; end
      3'd3: begin oa_c = r2_f1_q; ob_c = r2_f2_q; oc_c = r2_v_q;  end
      3'd4: begin oa_c = r2_f3_q; ob_c = r2_f1_q; oc_c = r2_v_q;  end
      default: begin oa_c = r2_v_q; ob_c = r2_f1_q; oc_c = r2_f2_q; end
    endcase
    case (r2_func_q)
      rhcc_pkg::FUNC_RGB2HSB: begin
        oa_c = W'(r2_h_q);
        ob_c = r2_s_q;
        oc_c = r2_v_q;
      end
      rhcc_pkg::FUNC_HSB2RGB, rhcc_pkg::FUNC_SCALE: begin
      end
      default: begin
        oa_c = '0;
        ob_c = '0;
        oc_c = '0;
      end
    endcase
  end

  logic o_vld_q;
  logic [rhcc_pkg::OUT_W-1:0] o_a_q, o_b_q, o_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (adv) begin
      o_vld_q <= r2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_a_q <= rhcc_pkg::OUT_W'(oa_c);
      o_b_q <= rhcc_pkg::OUT_W'(ob_c);
      o_c_q <= rhcc_pkg::OUT_W'(oc_c);
    end
  end

  assign out_valid_o = o_vld_q;
  assign out_a_o     = o_a_q;
  assign out_b_o     = o_b_q;
  assign out_c_o     = o_c_q;

`ifndef NO_ASSERTIONS
  // A stalled output beat holds its valid and its out_a and out_c data.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_a_o) && $stable(out_c_o))
    else $error("output beat changed while stalled");

  // The saturation remainder ends below the divisor for a non-grey pixel
  // whose max slot holds the largest channel (every operation but hsb to rgb).
  a_srem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld_q[F] && !dv_q[F].grey && (dv_q[F].func != rhcc_pkg::FUNC_HSB2RGB)
    |-> dv_q[F].srem < SRW'(dv_q[F].mx))
    else $error("saturation divider remainder out of range");

  // The hue remainder ends below six times delta for a non-grey pixel.
  a_hrem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld_q[F] && !dv_q[F].grey |-> dv_q[F].hrem < HRW'(dv_q[F].dsor))
    else $error("hue divider remainder out of range");
`endif

endmodule

FILE: verif/rgb_hsb_color_converter_unit_tb.sv
// ----------------------------------------------------------------------------
// rgb_hsb_color_converter_unit_tb: self-checking bench of the colour converter
// Drives a directed table and then random pixels through every operation,
// predicts each result in fixed point and compares the output beats in order,
// under several phases of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module rgb_hsb_color_converter_unit_tb;

  localparam int FRAC   = 12;
  localparam int ONE    = 1 << FRAC;
  localparam int LAT    = FRAC + 7;
  localparam int NRAND  = 900;
  localparam int LIMIT  = 400000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [rhcc_pkg::OUT_W-1:0] a;
    logic [rhcc_pkg::OUT_W-1:0] b;
    logic [rhcc_pkg::OUT_W-1:0] c;
  } colour_t;

  typedef struct {
    logic [1:0]                       func;
    logic signed [rhcc_pkg::IN_W-1:0] a;
    logic signed [rhcc_pkg::IN_W-1:0] b;
    logic signed [rhcc_pkg::IN_W-1:0] c;
    logic [rhcc_pkg::IN_W-1:0]        gain;
    bit                               typed;   // expected colour given in the row
    colour_t                          want;
  } pixel_row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] func_i;
  logic signed [rhcc_pkg::IN_W-1:0] in_a_i, in_b_i, in_c_i;
  logic [rhcc_pkg::IN_W-1:0] gain_i;
  logic [rhcc_pkg::OUT_W-1:0] out_a_o, out_b_o, out_c_o;

  rgb_hsb_color_converter_unit #(.FRAC_BITS(FRAC)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .in_a_i, .in_b_i,
    .in_c_i, .gain_i, .out_valid_o, .out_ready_i, .out_a_o, .out_b_o, .out_c_o
  );

  colour_t     pending_colours[$];
  int          mismatches = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          cycles = 0;
  int          send_idle_pct, recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: give up well past the slowest legal run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH beat %0d %s: got %0d want %0d", beats_out, what, got, want);
    mismatches++;
  endtask

  function automatic longint clamp_unit(input longint v);
    if (v < 0) return 0;
    if (v > ONE) return ONE;
    return v;
  endfunction

  // Red, green, blue (already clamped) to hue, saturation, brightness.
  function automatic void hsb_of(input longint r, input longint g, input longint b,
                                 output longint h, output longint s, output longint v);
    longint mx, mn, d, num;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    v = mx;
    if (d == 0) begin
      h = 0; s = 0;
      return;
    end
    s = (d * ONE) / mx;
    // Tie order: red first, then green, then blue.
    if (r == mx) num = g - b;
    else if (g == mx) num = 2 * d + (b - r);
    else num = 4 * d + (r - g);
    if (num < 0) num += 6 * d;
    h = (num * ONE) / (6 * d);
  endfunction

  function automatic colour_t rgb_of(input longint h, input longint s, input longint v);
    longint hd, sector, f, f1, f2, f3;
    colour_t o;
    hd = h * 6;
    sector = hd >>> FRAC;
    f = hd & (ONE - 1);
    f1 = (v * (ONE - s)) >>> FRAC;
    f2 = (v * (ONE - ((s * f) >>> FRAC))) >>> FRAC;
    f3 = (v * (ONE - ((s * (ONE - f)) >>> FRAC))) >>> FRAC;
    case (sector)
      0: o = '{v[12:0], f3[12:0], f1[12:0]};
      1: o = '{f2[12:0], v[12:0], f1[12:0]};
      2: o = '{f1[12:0], v[12:0], f3[12:0]};
      3: o = '{f1[12:0], f2[12:0], v[12:0]};
      4: o = '{f3[12:0], f1[12:0], v[12:0]};
      default: o = '{v[12:0], f1[12:0], f2[12:0]};
    endcase
    return o;
  endfunction

  function automatic colour_t convert_pixel(input pixel_row_t p);
    longint h, s, v;
    colour_t o;
    o = '0;
    case (p.func)
      rhcc_pkg::FUNC_RGB2HSB: begin
        hsb_of(clamp_unit(p.a), clamp_unit(p.b), clamp_unit(p.c), h, s, v);
        o = '{h[12:0], s[12:0], v[12:0]};
      end
      rhcc_pkg::FUNC_HSB2RGB: begin
        // Hue wraps modulo one turn on its low bits.
        h = longint'($unsigned(p.a)) & (ONE - 1);
        o = rgb_of(h, clamp_unit(p.b), clamp_unit(p.c));
      end
      rhcc_pkg::FUNC_SCALE: begin
        hsb_of(clamp_unit(p.a), clamp_unit(p.b), clamp_unit(p.c), h, s, v);
        v = (v * longint'(p.gain)) >>> FRAC;
        if (v > ONE) v = ONE;
        o = rgb_of(h, s, v);
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  // Hold the beat until accepted; queue its expected colour at acceptance.
  // Drop valid only when the sender idles, so a following beat goes out
  // back to back.
  task automatic send_pixel(input pixel_row_t p);
    colour_t want;
    want = p.typed ? p.want : convert_pixel(p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= p.func; in_a_i <= p.a; in_b_i <= p.b; in_c_i <= p.c; gain_i <= p.gain;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_colours.push_back(want);
    beats_in++;
  endtask

  // Receiver: stall at random, check every accepted beat against the oldest.
  always @(posedge clk_i) begin
    colour_t exp_c;
    if (out_valid_o && out_ready_i) begin
      beats_out++;
      if (pending_colours.size() == 0) begin
        report_mismatch("unexpected beat", out_a_o, 0);
      end else begin
        exp_c = pending_colours.pop_front();
        if (out_a_o !== exp_c.a) report_mismatch("out_a", out_a_o, exp_c.a);
        if (out_b_o !== exp_c.b) report_mismatch("out_b", out_b_o, exp_c.b);
        if (out_c_o !== exp_c.c) report_mismatch("out_c", out_c_o, exp_c.c);
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic signed [rhcc_pkg::IN_W-1:0] pick_chan();
    // Mostly in range, sometimes just outside, sometimes anything.
    case ($urandom_range(9))
      0: return rhcc_pkg::IN_W'($urandom);
      1: return -$signed(16'($urandom_range(64)));
      2: return rhcc_pkg::IN_W'(ONE + $urandom_range(64));
      3: return rhcc_pkg::IN_W'(ONE);
      4: return '0;
      default: return rhcc_pkg::IN_W'($urandom_range(ONE));
    endcase
  endfunction

  pixel_row_t directed[$];
  pixel_row_t px;

  initial begin
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_ni = 1'b0; in_valid_i = 1'b0;
    func_i = '0; in_a_i = '0; in_b_i = '0; in_c_i = '0; gain_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: grey, extremes, each sector, wrap and clamp cases.
    directed = '{
      '{rhcc_pkg::FUNC_RGB2HSB, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1,
        '{13'd0, 13'd0, 13'd0}},
      '{rhcc_pkg::FUNC_RGB2HSB, 16'sd2048, 16'sd2048, 16'sd2048, 16'd0, 1,
        '{13'd0, 13'd0, 13'd2048}},
      '{rhcc_pkg::FUNC_RGB2HSB, 16'sd4096, 16'sd0, 16'sd0, 16'd0, 1,
        '{13'd0, 13'd4096, 13'd4096}},
      '{rhcc_pkg::FUNC_RGB2HSB, 16'sh7FFF, -16'sd32768, 16'sh7FFF, 16'd0, 0, '0},
      '{rhcc_pkg::FUNC_RGB2HSB, 16'sd100, 16'sd4096, 16'sd4096, 16'd0, 0, '0},
      '{rhcc_pkg::FUNC_RGB2HSB, 16'sd4096, 16'sd100, 16'sd300, 16'd0, 0, '0},
      '{rhcc_pkg::FUNC_RGB2HSB, 16'sd300, 16'sd100, 16'sd4000, 16'd0, 0, '0},
      '{rhcc_pkg::FUNC_HSB2RGB, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1,
        '{13'd0, 13'd0, 13'd0}},
      '{rhcc_pkg::FUNC_HSB2RGB, 16'sd1000, 16'sd0, 16'sd4096, 16'd0, 1,
        '{13'd4096, 13'd4096, 13'd4096}},
      '{rhcc_pkg::FUNC_HSB2RGB, 16'sd200, 16'sd4096, 16'sd4096, 16'd0, 0, '0},
      '{rhcc_pkg::FUNC_HSB2RGB, 16'sd900, 16'sd3000, 16'sd4096, 16'd0, 0, '0},
      '{rhcc_pkg::FUNC_HSB2RGB, 16'sd1600, 16'sd3000, 16'sd3000, 16'd0, 0, '0},
      '{rhcc_pkg::FUNC_HSB2RGB, 16'sd2300, 16'sd4096, 16'sd2000, 16'd0, 0, '0},
      '{rhcc_pkg::FUNC_HSB2RGB, 16'sd3000, 16'sd2000, 16'sd4096, 16'd0, 0, '0},
      '{rhcc_pkg::FUNC_HSB2RGB, 16'sd4095, 16'sd4096, 16'sd4096, 16'd0, 0, '0},
      '{rhcc_pkg::FUNC_HSB2RGB, -16'sd1, -16'sd32768, 16'sh7FFF, 16'd0, 0, '0},
      '{rhcc_pkg::FUNC_HSB2RGB, -16'sd32768, 16'sh7FFF, -16'sd5, 16'd0, 0, '0},
      '{rhcc_pkg::FUNC_SCALE, 16'sd4096, 16'sd2000, 16'sd0, 16'hFFFF, 0, '0},
      '{rhcc_pkg::FUNC_SCALE, 16'sd1000, 16'sd3000, 16'sd500, 16'd0, 0, '0},
      '{rhcc_pkg::FUNC_SCALE, 16'sd1000, 16'sd3000, 16'sd500, 16'd2048, 0, '0},
      '{rhcc_pkg::FUNC_SCALE, 16'sd2000, 16'sd2000, 16'sd2000, 16'd4096, 0, '0},
      '{FUNC_UNUSED, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1, '0},
      '{FUNC_UNUSED, -16'sd32768, -16'sd32768, -16'sd32768, 16'h0, 1, '0}
    };
    foreach (directed[i]) send_pixel(directed[i]);

    // Random part in four idling phases.
    for (int n = 0; n < NRAND; n++) begin
      case (n * 4 / NRAND)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      px.func = ($urandom_range(19) == 0) ? FUNC_UNUSED : 2'($urandom_range(2));
      px.a = (px.func == rhcc_pkg::FUNC_HSB2RGB && $urandom_range(1))
             ? rhcc_pkg::IN_W'($urandom) : pick_chan();
      px.b = pick_chan();
      px.c = pick_chan();
      px.gain = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2 * ONE));
      px.typed = 0;
      px.want = '0;
      send_pixel(px);
    end
    in_valid_i <= 1'b0;

    // Drain, then let the pipeline settle for any late beat.
    while (pending_colours.size() != 0) @(posedge clk_i);
    repeat (4 * LAT) @(posedge clk_i);

    $display("Sent %0d pixels over all three operations and the unused code,", beats_in);
    $display("checked %0d output beats under four idle/stall phases.", beats_out);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
